// ===== rtl/core/hsvct_pkg.sv =====
// Shared types, constants and lookup tables for the HSV color centroid tracker.
// Depends on nothing; every other file imports it.
package hsvct_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 13;
    localparam int SUM_W      = 36;
    localparam int CNT_W      = 25;
    localparam int DEN_W      = CNT_W + SIZE_W;
    localparam int REM_W      = 56;
    localparam int Q_W        = 18;
    localparam int DIV_STEPS  = Q_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SDIV_W     = 20;
    localparam int HDIV_W     = 17;
    localparam int SDIV_NUM   = 255 * 4096;
    localparam int HDIV_NUM   = 180 * 4096;

    typedef enum logic [2:0] {
        REG_HUE_LOW  = 3'd0,
        REG_HUE_HIGH = 3'd1,
        REG_SAT_LOW  = 3'd2,
        REG_SAT_HIGH = 3'd3,
        REG_VAL_LOW  = 3'd4,
        REG_VAL_HIGH = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]        hue_low;
        logic [7:0]        hue_high;
        logic [7:0]        sat_low;
        logic [7:0]        sat_high;
        logic [7:0]        val_low;
        logic [7:0]        val_high;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic den_load;
        logic save_x;
        logic div_load;
        logic div_step;
        logic sel_y;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic fin;
        logic out_busy;
    } t_sts;

    typedef logic [255:0][SDIV_W-1:0] t_sdiv_tab;
    typedef logic [255:0][HDIV_W-1:0] t_hdiv_tab;

    // Bitwise long division with round half to even; only used to build tables.
    function automatic logic [20:0] f_div_re(input logic [20:0] n, input logic [20:0] d);
        logic [20:0] q;
        logic [21:0] r;
        q = '0;
        r = '0;
        for (int i = 20; i >= 0; i--) begin
            r = {r[20:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        if (({r[20:0], 1'b0} > {1'b0, d}) || (({r[20:0], 1'b0} == {1'b0, d}) && q[0]))
            q = q + 21'd1;
        return q;
    endfunction

    function automatic t_sdiv_tab f_sdiv_tab();
        t_sdiv_tab tab;
        logic [20:0] q;
        tab = '0;
        for (int v = 1; v < 256; v++) begin
            q      = f_div_re(21'(SDIV_NUM), 21'(v));
            tab[v] = q[SDIV_W-1:0];
        end
        return tab;
    endfunction

    function automatic t_hdiv_tab f_hdiv_tab();
        t_hdiv_tab tab;
        logic [20:0] q;
        tab = '0;
        for (int d = 1; d < 256; d++) begin
            q      = f_div_re(21'(HDIV_NUM), 21'(6 * d));
            tab[d] = q[HDIV_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sdiv_tab SDIV_TAB = f_sdiv_tab();
    localparam t_hdiv_tab HDIV_TAB = f_hdiv_tab();

endpackage

// ===== rtl/core/hsvct_ctrl.sv =====
// Controller of the tracker: accepts pixels, waits for the frame end and
// sequences the two centroid divisions. Depends on hsvct_pkg.
module hsvct_ctrl
    import hsvct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_ACC   = 6'b000001,
        ST_DRAIN = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_sel_y, n_sel_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_step  <= '0;
            r_sel_y <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sel_y <= n_sel_y;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sel_y = r_sel_y;
        o_cmd   = '0;
        o_cmd.sel_y = r_sel_y;
        o_ready = 1'b0;
        case (r_state)
            ST_ACC: begin
                o_ready = 1'b1;
                if (i_in_fire && i_sts.in_last)
                    n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_sts.fin) begin
                    n_state = ST_MUL;
                    n_sel_y = 1'b0;
                end
            end
            ST_MUL: begin
                o_cmd.den_load = 1'b1;
                o_cmd.save_x   = r_sel_y;
                n_state        = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    if (r_sel_y) begin
                        n_state = ST_OUT;
                    end else begin
                        n_sel_y = 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    a_fin_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.fin |-> r_state == ST_DRAIN)
        else $error("frame end reached the accumulators outside the drain wait");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_fire && i_sts.in_last) |=> r_state == ST_DRAIN)
        else $error("last pixel of a frame did not stop intake");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_step <= STEP_W'(DIV_STEPS - 1))
        else $error("division step counter ran past its last step");

endmodule

// ===== rtl/core/hsvct_datapath.sv =====
// Datapath of the tracker: raster position, HSV pipeline, threshold test,
// running sums, the shared restoring divider and the output register.
// Depends on hsvct_pkg.
module hsvct_datapath
    import hsvct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_fire,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    input  logic        i_sof,
    input  t_cmd        i_cmd,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [15:0] o_center_x,
    output logic [15:0] o_center_y,
    output logic        o_found
);

    // Effective frame size.
    logic [SIZE_W-1:0] w_eff, h_eff;
    always_comb begin
        if (i_cfg.frame_width == '0)
            w_eff = SIZE_W'(1);
        else if (i_cfg.frame_width > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = i_cfg.frame_width;
        if (i_cfg.frame_height == '0)
            h_eff = SIZE_W'(1);
        else if (i_cfg.frame_height > SIZE_W'(MAX_HEIGHT))
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = i_cfg.frame_height;
    end

    // Raster position of the next pixel.
    logic [COL_W-1:0] r_col, col_cur;
    logic [ROW_W-1:0] r_row, row_cur;
    logic             col_wrap, row_wrap;

    assign col_cur  = i_sof ? '0 : r_col;
    assign row_cur  = i_sof ? '0 : r_row;
    assign col_wrap = (SIZE_W'(col_cur) + SIZE_W'(1)) >= w_eff;
    assign row_wrap = (SIZE_W'(row_cur) + SIZE_W'(1)) >= h_eff;
    assign o_sts.in_last = col_wrap && row_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_in_fire) begin
            r_col <= col_wrap ? '0 : col_cur + 1'b1;
            if (col_wrap)
                r_row <= row_wrap ? '0 : row_cur + 1'b1;
            else
                r_row <= row_cur;
        end
    end

    // Stage 1: max, min and hue base.
    logic [7:0] vmax, vmin, diff;
    logic signed [11:0] base;
    always_comb begin
        vmax = i_blue;
        vmin = i_blue;
        if (i_green > vmax) vmax = i_green;
        if (i_red > vmax)   vmax = i_red;
        if (i_green < vmin) vmin = i_green;
        if (i_red < vmin)   vmin = i_red;
        diff = vmax - vmin;
        if (vmax == i_red)
            base = $signed({4'd0, i_green}) - $signed({4'd0, i_blue});
        else if (vmax == i_green)
            base = $signed({4'd0, i_blue}) - $signed({4'd0, i_red})
                 + $signed({3'd0, diff, 1'b0});
        else
            base = $signed({4'd0, i_red}) - $signed({4'd0, i_green})
                 + $signed({2'd0, diff, 2'b0});
    end

    logic               r_s1_vld, r_s2_vld, r_s3_vld;
    logic               r_s1_sof, r_s2_sof, r_s3_sof;
    logic               r_s1_last, r_s2_last, r_s3_last;
    logic [COL_W-1:0]   r_s1_col, r_s2_col, r_s3_col;
    logic [ROW_W-1:0]   r_s1_row, r_s2_row, r_s3_row;
    logic [7:0]         r_s1_v, r_s2_v, r_s3_v;
    logic [7:0]         r_s1_diff, r_s2_diff;
    logic signed [11:0] r_s1_base, r_s2_base;
    logic [SDIV_W-1:0]  r_s2_sdiv;
    logic [HDIV_W-1:0]  r_s2_hdiv;
    logic [27:0]        r_s3_sp;
    logic signed [29:0] r_s3_hp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_in_fire;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sof  <= i_sof;
        r_s1_last <= o_sts.in_last;
        r_s1_col  <= col_cur;
        r_s1_row  <= row_cur;
        r_s1_v    <= vmax;
        r_s1_diff <= diff;
        r_s1_base <= base;
        // Stage 2: reciprocal tables.
        r_s2_sof  <= r_s1_sof;
        r_s2_last <= r_s1_last;
        r_s2_col  <= r_s1_col;
        r_s2_row  <= r_s1_row;
        r_s2_v    <= r_s1_v;
        r_s2_diff <= r_s1_diff;
        r_s2_base <= r_s1_base;
        r_s2_sdiv <= SDIV_TAB[r_s1_v];
        r_s2_hdiv <= HDIV_TAB[r_s1_diff];
        // Stage 3: products.
        r_s3_sof  <= r_s2_sof;
        r_s3_last <= r_s2_last;
        r_s3_col  <= r_s2_col;
        r_s3_row  <= r_s2_row;
        r_s3_v    <= r_s2_v;
        r_s3_sp   <= 28'(r_s2_diff * r_s2_sdiv);
        r_s3_hp   <= 30'(r_s2_base * $signed({1'b0, r_s2_hdiv}));
    end

    // Stage 4: finish H and S, threshold, accumulate.
    logic [28:0]        s_round;
    logic [8:0]         sat;
    logic signed [30:0] h_round;
    logic signed [18:0] h_floor;
    logic [8:0]         hue;
    logic               match;

    always_comb begin
        s_round = {1'b0, r_s3_sp} + 29'd2048;
        sat     = s_round[20:12];
        h_round = {r_s3_hp[29], r_s3_hp} + 31'sd2048;
        h_floor = h_round[30:12];
        if (h_floor < 0)
            hue = 9'(h_floor + 19'sd180);
        else
            hue = h_floor[8:0];
        match = (hue >= {1'b0, i_cfg.hue_low}) && (hue <= {1'b0, i_cfg.hue_high})
             && (sat >= {1'b0, i_cfg.sat_low}) && (sat <= {1'b0, i_cfg.sat_high})
             && (r_s3_v >= i_cfg.val_low) && (r_s3_v <= i_cfg.val_high);
    end

    logic [SUM_W-1:0] r_csum, r_rsum, csum_nx, rsum_nx, r_fx_sum, r_fy_sum;
    logic [CNT_W-1:0] r_cnt, cnt_nx, r_fcnt;

    always_comb begin
        csum_nx = r_s3_sof ? '0 : r_csum;
        rsum_nx = r_s3_sof ? '0 : r_rsum;
        cnt_nx  = r_s3_sof ? '0 : r_cnt;
        if (match) begin
            csum_nx = csum_nx + SUM_W'(r_s3_col);
            rsum_nx = rsum_nx + SUM_W'(r_s3_row);
            cnt_nx  = cnt_nx + 1'b1;
        end
    end

    assign o_sts.fin = r_s3_vld && r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csum <= '0;
            r_rsum <= '0;
            r_cnt  <= '0;
        end else if (r_s3_vld) begin
            r_csum <= r_s3_last ? '0 : csum_nx;
            r_rsum <= r_s3_last ? '0 : rsum_nx;
            r_cnt  <= r_s3_last ? '0 : cnt_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sts.fin) begin
            r_fx_sum <= csum_nx;
            r_fy_sum <= rsum_nx;
            r_fcnt   <= cnt_nx;
        end
    end

    // Restoring divider: q = (sum*2^17 + den) / (2*den), one bit per cycle.
    logic [DEN_W-1:0] r_den;
    logic [REM_W-1:0] r_rem, r_dsh;
    logic [Q_W-1:0]   r_q, r_qx;
    logic [SUM_W-1:0] div_sum;
    logic             fits;

    assign div_sum = i_cmd.sel_y ? r_fy_sum : r_fx_sum;
    assign fits    = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.den_load)
            r_den <= DEN_W'(r_fcnt * (i_cmd.sel_y ? h_eff : w_eff));
        if (i_cmd.save_x)
            r_qx <= r_q;
        if (i_cmd.div_load) begin
            r_rem <= (REM_W'(div_sum) << 17) + REM_W'(r_den);
            r_dsh <= REM_W'(r_den) << (Q_W);
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (fits)
                r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[Q_W-2:0], fits};
        end
    end

    function automatic logic [15:0] f_sat16(input logic [Q_W-1:0] q);
        return (q > Q_W'(16'hFFFF)) ? 16'hFFFF : q[15:0];
    endfunction

    // Output register.
    logic r_out_valid;
    logic found_nx;
    assign found_nx       = r_fcnt != '0;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.out_load)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_center_x <= found_nx ? f_sat16(r_qx) : 16'd0;
            o_center_y <= found_nx ? f_sat16(r_q) : 16'd0;
            o_found    <= found_nx;
        end
    end

endmodule

// ===== rtl/core/hsv_color_centroid_tracker.sv =====
// Top level of the HSV color centroid tracker: configuration registers and
// stream ports around hsvct_ctrl and hsvct_datapath. Depends on hsvct_pkg.
// Throughput: one pixel item per cycle within a frame; after the last pixel,
// intake pauses for the pipeline drain and two 18-step restoring divisions
// that share one subtractor, and also while the previous result item still
// waits at the output.
// Reset (synchronous, active low) restores default bounds and a 640 by 480
// frame and clears position, sums and the output valid flag.
module hsv_color_centroid_tracker
    import hsvct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
    input  logic        i_s_axis_tuser,   // start_of_frame
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // center_x [15:0], center_y [31:16]
    output logic        o_m_axis_tuser    // found
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low      <= 8'd25;
            r_cfg.hue_high     <= 8'd35;
            r_cfg.sat_low      <= 8'd75;
            r_cfg.sat_high     <= 8'd255;
            r_cfg.val_low      <= 8'd50;
            r_cfg.val_high     <= 8'd255;
            r_cfg.frame_width  <= SIZE_W'(640);
            r_cfg.frame_height <= SIZE_W'(480);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_HUE_LOW:  r_cfg.hue_low      <= i_cfg_data[7:0];
                REG_HUE_HIGH: r_cfg.hue_high     <= i_cfg_data[7:0];
                REG_SAT_LOW:  r_cfg.sat_low      <= i_cfg_data[7:0];
                REG_SAT_HIGH: r_cfg.sat_high     <= i_cfg_data[7:0];
                REG_VAL_LOW:  r_cfg.val_low      <= i_cfg_data[7:0];
                REG_VAL_HIGH: r_cfg.val_high     <= i_cfg_data[7:0];
                REG_WIDTH:    r_cfg.frame_width  <= i_cfg_data;
                REG_HEIGHT:   r_cfg.frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic in_fire;
    t_cmd cmd;
    t_sts sts;
    logic [15:0] center_x, center_y;

    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    hsvct_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_sts     (sts),
        .o_ready   (o_s_axis_tready),
        .o_cmd     (cmd)
    );

    hsvct_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_fire   (in_fire),
        .i_blue      (i_s_axis_tdata[7:0]),
        .i_green     (i_s_axis_tdata[15:8]),
        .i_red       (i_s_axis_tdata[23:16]),
        .i_sof       (i_s_axis_tuser),
        .i_cmd       (cmd),
        .i_out_ready (i_m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_center_x  (center_x),
        .o_center_y  (center_y),
        .o_found     (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {center_y, center_x};

endmodule
